// ----- hw/rtl/ipe_pkg.sv -----
// ----------------------------------------------------------------------------
// ipe_pkg
// shared types and constants of the ip-in-ip encapsulator
// ----------------------------------------------------------------------------
`default_nettype none

package ipe_pkg;

    localparam logic CMD_PKT  = 1'b0;
    localparam logic CMD_BIND = 1'b1;

    localparam logic [7:0]  VER_IHL     = 8'h45;
    localparam logic [7:0]  OUTER_TTL   = 8'd200;
    localparam logic [7:0]  OUTER_PROTO = 8'd4;
    localparam logic [15:0] HDR_BYTES   = 16'd20;
    localparam logic [2:0]  WORD_BYTES  = 3'd4;

    localparam logic [2:0]  HDR_LAST_POS = 3'd4;
    localparam logic [2:0]  POS_PASS     = 3'd5;

    localparam logic [3:0]  IDX_HDR0  = 4'd0;
    localparam logic [3:0]  IDX_HDR1  = 4'd1;
    localparam logic [3:0]  IDX_HDR2  = 4'd2;
    localparam logic [3:0]  IDX_HDR3  = 4'd3;
    localparam logic [3:0]  IDX_HDR4  = 4'd4;
    localparam logic [3:0]  IDX_IN0   = 4'd5;
    localparam logic [3:0]  IDX_IN1   = 4'd6;
    localparam logic [3:0]  IDX_IN2   = 4'd7;
    localparam logic [3:0]  IDX_IN3   = 4'd8;
    localparam logic [3:0]  IDX_LAST  = 4'd9;

    typedef struct packed {
        logic        en;
        logic [2:0]  idx;
        logic [31:0] home;
        logic [31:0] care_of;
        logic        enable;
    } t_bind_wr;

    typedef struct packed {
        logic             valid;
        logic             burst;
        logic [31:0]      word;
        logic             last;
        logic [2:0]       bytes;
        logic             runt;
        logic [4:0][31:0] inner;
        logic [7:0]       tos;
        logic [15:0]      len;
        logic [31:0]      dst;
    } t_emit;

endpackage

`default_nettype wire

// ----- hw/rtl/ipe_binding.sv -----
// ----------------------------------------------------------------------------
// ipe_binding
// binding table of home to care-of addresses with priority lookup
// ----------------------------------------------------------------------------
`default_nettype none

module ipe_binding #(
    parameter int unsigned BINDING_ENTRIES = 8
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire ipe_pkg::t_bind_wr i_wr,
    input  wire logic [31:0]     i_dst,
    output logic [31:0]          o_next_hop
);

    logic [31:0] r_home    [BINDING_ENTRIES];
    logic [31:0] r_care_of [BINDING_ENTRIES];
    logic [BINDING_ENTRIES-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            for (int i = 0; i < BINDING_ENTRIES; i++) begin
                if (int'(i_wr.idx) == i) begin
                    r_valid[i] <= i_wr.enable;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            for (int i = 0; i < BINDING_ENTRIES; i++) begin
                if (int'(i_wr.idx) == i) begin
                    r_home[i]    <= i_wr.home;
                    r_care_of[i] <= i_wr.care_of;
                end
            end
        end
    end

    // lowest matching entry wins
    always_comb begin
        o_next_hop = i_dst;
        for (int i = BINDING_ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && r_home[i] == i_dst) begin
                o_next_hop = r_care_of[i];
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ipe_emitter.sv -----
// ----------------------------------------------------------------------------
// ipe_emitter
// output register bank, outer header build and checksum, beat sequencing
// ----------------------------------------------------------------------------
`default_nettype none

module ipe_emitter (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire ipe_pkg::t_emit i_load,
    input  wire logic [31:0]   i_src,
    output logic               o_free,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [31:0]        o_word,
    output logic               o_last,
    output logic [2:0]         o_bytes,
    output logic               o_first,
    output logic [31:0]        o_next_hop,
    output logic               o_runt
);

    ipe_pkg::t_emit r_e;
    logic           r_busy;
    logic [3:0]     r_idx;
    logic           take;
    logic           last_beat;
    logic [18:0]    sum;
    logic [16:0]    fold1;
    logic [15:0]    fold2;
    logic [15:0]    csum;

    assign take      = r_busy && i_ready;
    assign last_beat = !r_e.burst || r_idx == ipe_pkg::IDX_LAST;
    assign o_free    = !r_busy || (take && last_beat);
    assign o_valid   = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= ipe_pkg::IDX_HDR0;
        end else if (i_load.valid) begin
            r_busy <= 1'b1;
            r_idx  <= ipe_pkg::IDX_HDR0;
        end else if (take) begin
            if (last_beat) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load.valid) begin
            r_e <= i_load;
        end
    end

    // one's complement sum over the outer header, identification word is zero
    always_comb begin
        sum = 19'({ipe_pkg::VER_IHL, r_e.tos}) + 19'(r_e.len)
            + 19'({ipe_pkg::OUTER_TTL, ipe_pkg::OUTER_PROTO})
            + 19'(i_src[31:16]) + 19'(i_src[15:0])
            + 19'(r_e.dst[31:16]) + 19'(r_e.dst[15:0]);
        fold1 = 17'(sum[15:0]) + 17'(sum[18:16]);
        fold2 = fold1[15:0] + 16'(fold1[16]);
        csum  = ~fold2;
    end

    always_comb begin
        o_word     = r_e.word;
        o_last     = r_e.last;
        o_bytes    = r_e.bytes;
        o_first    = 1'b0;
        o_next_hop = '0;
        o_runt     = r_e.runt;
        if (r_e.burst) begin
            o_last  = 1'b0;
            o_bytes = ipe_pkg::WORD_BYTES;
            o_runt  = 1'b0;
            case (r_idx)
                ipe_pkg::IDX_HDR0: begin
                    o_word     = {ipe_pkg::VER_IHL, r_e.tos, r_e.len};
                    o_first    = 1'b1;
                    o_next_hop = r_e.dst;
                end
                ipe_pkg::IDX_HDR1: o_word = '0;
                ipe_pkg::IDX_HDR2: o_word = {ipe_pkg::OUTER_TTL, ipe_pkg::OUTER_PROTO, csum};
                ipe_pkg::IDX_HDR3: o_word = i_src;
                ipe_pkg::IDX_HDR4: o_word = r_e.dst;
                ipe_pkg::IDX_IN0:  o_word = r_e.inner[0];
                ipe_pkg::IDX_IN1:  o_word = r_e.inner[1];
                ipe_pkg::IDX_IN2:  o_word = r_e.inner[2];
                ipe_pkg::IDX_IN3:  o_word = r_e.inner[3];
                ipe_pkg::IDX_LAST: begin
                    o_word = r_e.inner[4];
                    o_last = r_e.last;
                end
                default: o_word = '0;
            endcase
        end
    end

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load.valid |-> o_free)
        else $error("emitter loaded while a transaction is still pending");

    a_load_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load.valid |=> r_busy && r_idx == ipe_pkg::IDX_HDR0)
        else $error("load did not start at the first beat");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_idx <= ipe_pkg::IDX_LAST)
        else $error("beat index out of range");

    a_single_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !r_e.burst |-> r_idx == ipe_pkg::IDX_HDR0)
        else $error("single transaction advanced its beat index");

endmodule

`default_nettype wire

// ----- hw/rtl/ip_in_ip_encapsulator.sv -----
// ----------------------------------------------------------------------------
// ip_in_ip_encapsulator
// wraps ipv4 packets in an outer ip-in-ip header with binding-table lookup
// ----------------------------------------------------------------------------
// Packet words and binding writes enter on the slave stream (tuser = 1 marks a
// binding write) into an input register; the first four words of each packet
// are held back, and on the fifth the block queues a ten-beat burst of outer
// header plus buffered inner header, looking up the outer destination in the
// binding table in that same cycle. Every later word passes through with one
// output beat. Throughput is one transaction per cycle while output is ready,
// set by the single output beat register: pass-through words and binding writes
// sustain one per cycle; after a packet's fifth word, the next word needing an
// output beat waits while the burst drains. A packet ending before 20 bytes
// yields one beat flagged runt. Words pass the input and emitter registers.
`default_nettype none

module ip_in_ip_encapsulator #(
    parameter int unsigned BINDING_ENTRIES = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [31:0]   i_cfg_data,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // packet_word, valid_bytes, entry_index, home_address, care_of_address,
    // entry_enable, zero pad
    input  wire logic [103:0]  s_axis_tdata,
    input  wire logic          s_axis_tlast,
    // cmd
    input  wire logic [0:0]    s_axis_tuser,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // out_word, out_bytes, next_hop, zero pad
    output logic [71:0]        m_axis_tdata,
    output logic               m_axis_tlast,
    // out_first, runt_dropped
    output logic [1:0]         m_axis_tuser
);

    logic [31:0]  r_src;
    logic         r_in_valid;
    logic         r_cmd;
    logic [31:0]  r_word;
    logic         r_last;
    logic [2:0]   r_vb;
    logic [2:0]   r_eidx;
    logic [31:0]  r_home;
    logic [31:0]  r_coa;
    logic         r_een;
    logic [2:0]   r_pos;
    logic [31:0]  r_hbuf [4];

    logic         em_free;
    logic         needs_out;
    logic         adv;
    logic         is_pkt;
    logic         runt;
    logic [2:0]   vbn;
    logic [31:0]  lookup_hop;
    logic [2:0]   n_pos;

    ipe_pkg::t_bind_wr bind_wr;
    ipe_pkg::t_emit    em_load;

    logic [31:0]  o_word;
    logic [2:0]   o_bytes;
    logic [31:0]  o_hop;
    logic         o_first;
    logic         o_runt;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src <= '0;
        end else if (i_cfg_valid) begin
            r_src <= i_cfg_data;
        end
    end

    assign is_pkt    = r_cmd == ipe_pkg::CMD_PKT;
    assign vbn       = (r_vb == 3'd0 || r_vb > ipe_pkg::WORD_BYTES) ? ipe_pkg::WORD_BYTES : r_vb;
    assign runt      = r_last && r_pos < ipe_pkg::POS_PASS
                       && (r_pos < ipe_pkg::HDR_LAST_POS || vbn < ipe_pkg::WORD_BYTES);
    assign needs_out = is_pkt && (r_pos >= ipe_pkg::HDR_LAST_POS || runt);
    assign adv       = r_in_valid && (!needs_out || em_free);
    assign s_axis_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_cmd  <= s_axis_tuser[0];
            r_word <= s_axis_tdata[31:0];
            r_vb   <= s_axis_tdata[34:32];
            r_eidx <= s_axis_tdata[37:35];
            r_home <= s_axis_tdata[69:38];
            r_coa  <= s_axis_tdata[101:70];
            r_een  <= s_axis_tdata[102];
            r_last <= s_axis_tlast;
        end
    end

    always_comb begin
        n_pos = r_pos;
        if (runt) begin
            n_pos = '0;
        end else if (r_pos >= ipe_pkg::POS_PASS) begin
            n_pos = r_last ? 3'd0 : r_pos;
        end else if (r_pos == ipe_pkg::HDR_LAST_POS) begin
            n_pos = r_last ? 3'd0 : ipe_pkg::POS_PASS;
        end else begin
            n_pos = r_pos + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (adv && is_pkt) begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && is_pkt && r_pos < ipe_pkg::HDR_LAST_POS) begin
            r_hbuf[r_pos[1:0]] <= r_word;
        end
    end

    always_comb begin
        bind_wr.en      = adv && !is_pkt;
        bind_wr.idx     = r_eidx;
        bind_wr.home    = r_home;
        bind_wr.care_of = r_coa;
        bind_wr.enable  = r_een;
    end

    ipe_binding #(
        .BINDING_ENTRIES(BINDING_ENTRIES)
    ) u_binding (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (bind_wr),
        .i_dst     (r_word),
        .o_next_hop(lookup_hop)
    );

    always_comb begin
        em_load.valid    = adv && needs_out;
        em_load.burst    = !runt && r_pos == ipe_pkg::HDR_LAST_POS;
        em_load.word     = runt ? 32'd0 : r_word;
        em_load.last     = runt ? 1'b0 : r_last;
        em_load.bytes    = runt ? 3'd0 : (r_last ? vbn : ipe_pkg::WORD_BYTES);
        em_load.runt     = runt;
        em_load.inner    = {r_word, r_hbuf[3], r_hbuf[2], r_hbuf[1], r_hbuf[0]};
        em_load.tos      = r_hbuf[0][23:16];
        em_load.len      = ipe_pkg::HDR_BYTES + r_hbuf[0][15:0];
        em_load.dst      = lookup_hop;
    end

    ipe_emitter u_emitter (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (em_load),
        .i_src     (r_src),
        .o_free    (em_free),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_word    (o_word),
        .o_last    (m_axis_tlast),
        .o_bytes   (o_bytes),
        .o_first   (o_first),
        .o_next_hop(o_hop),
        .o_runt    (o_runt)
    );

    assign m_axis_tdata = {5'd0, o_hop, o_bytes, o_word};
    assign m_axis_tuser = {o_runt, o_first};

endmodule

`default_nettype wire

// ----- tb/tb_ip_in_ip_encapsulator.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ip_in_ip_encapsulator
// self-checking bench for the ip-in-ip encapsulator
// ----------------------------------------------------------------------------
// A directed stimulus table runs first. It covers runts, binding priority,
// disabled bindings, length wrap, exactly twenty bytes and odd byte counts.
// Random packet traffic with interleaved binding writes follows, in three
// idling phases, each under a different source address. Every output
// transaction is compared against a local encapsulation predictor.
// ----------------------------------------------------------------------------
module tb_ip_in_ip_encapsulator;

    localparam int NUM_BINDINGS = 8;

    typedef struct packed {
        logic        cmd;
        logic [31:0] word;
        logic        last;
        logic [2:0]  vb;
        logic [2:0]  idx;
        logic [31:0] home;
        logic [31:0] care;
        logic        en;
    } t_pkt_item;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
        logic [2:0]  bytes;
        logic        first;
        logic [31:0] hop;
        logic        runt;
    } t_beat;

    typedef struct packed {
        t_pkt_item it;
        logic      typed;
        t_beat     want;
    } t_stim_row;

    localparam t_beat RUNT_BEAT = '{32'h0, 1'b0, 3'd0, 1'b0, 32'h0, 1'b1};

    localparam logic [31:0] HOME_A = 32'h0A00_0001;
    localparam logic [31:0] HOME_B = 32'h0A00_0002;
    localparam logic [31:0] CARE_0 = 32'hC0A8_0101;
    localparam logic [31:0] CARE_3 = 32'hC0A8_0303;
    localparam logic [31:0] CARE_7 = 32'hC0A8_0707;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_cfg_valid;
    logic           o_cfg_ready;
    logic [31:0]    i_cfg_data;
    logic           s_axis_tvalid;
    logic           s_axis_tready;
    // packet_word, valid_bytes, entry_index, home_address, care_of_address,
    // entry_enable, zero pad
    logic [103:0]   s_axis_tdata;
    logic           s_axis_tlast;
    // cmd
    logic [0:0]     s_axis_tuser;
    logic           m_axis_tvalid;
    logic           m_axis_tready;
    // out_word, out_bytes, next_hop, zero pad
    logic [71:0]    m_axis_tdata;
    logic           m_axis_tlast;
    // out_first, runt_dropped
    logic [1:0]     m_axis_tuser;

    ip_in_ip_encapsulator #(
        .BINDING_ENTRIES (NUM_BINDINGS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // predictor state
    logic [31:0] src_addr;
    logic [31:0] inner_hdr [5];
    logic [2:0]  hdr_pos;
    logic [31:0] bind_home  [NUM_BINDINGS];
    logic [31:0] bind_care  [NUM_BINDINGS];
    logic        bind_valid [NUM_BINDINGS];

    t_beat       expected_beats [$];
    t_stim_row   directed_rows [$];
    logic [31:0] home_pool [4];

    int mismatches;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles_left;
    bit hold_request;

    initial begin
        i_clk = 1'b0;
    end

    always #10 i_clk = ~i_clk;

    initial begin
        #8_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t mismatch %s: got %h, want %h", $time, what, got, want);
        mismatches++;
    endtask

    function automatic logic [31:0] find_next_hop(input logic [31:0] dst);
        logic [31:0] hop;
        bit          found;
        hop = dst;
        found = 0;
        for (int i = 0; i < NUM_BINDINGS; i++) begin
            if (!found && bind_valid[i] && bind_home[i] == dst) begin
                hop = bind_care[i];
                found = 1;
            end
        end
        return hop;
    endfunction

    task automatic encap_predict(input t_pkt_item it, input bit keep);
        logic [2:0]  nb;
        logic [31:0] outer [5];
        logic [31:0] hop;
        logic [31:0] csum;
        t_beat       b;
        if (it.cmd == ipe_pkg::CMD_BIND) begin
            if (it.idx < NUM_BINDINGS) begin
                bind_home[it.idx]  = it.home;
                bind_care[it.idx]  = it.care;
                bind_valid[it.idx] = it.en;
            end
            return;
        end
        nb = (it.vb == 3'd0 || it.vb > ipe_pkg::WORD_BYTES) ? ipe_pkg::WORD_BYTES : it.vb;
        if (hdr_pos == ipe_pkg::POS_PASS) begin
            b = '{it.word, it.last, it.last ? nb : ipe_pkg::WORD_BYTES, 1'b0, 32'h0, 1'b0};
            if (keep) expected_beats.push_back(b);
            if (it.last) hdr_pos = 3'd0;
            return;
        end
        inner_hdr[hdr_pos] = it.word;
        if (it.last && (hdr_pos != ipe_pkg::HDR_LAST_POS || nb != ipe_pkg::WORD_BYTES)) begin
            hdr_pos = 3'd0;
            if (keep) expected_beats.push_back(RUNT_BEAT);
            return;
        end
        if (hdr_pos != ipe_pkg::HDR_LAST_POS) begin
            hdr_pos = hdr_pos + 3'd1;
            return;
        end
        hop = find_next_hop(inner_hdr[4]);
        outer[0] = {ipe_pkg::VER_IHL, inner_hdr[0][23:16],
                    ipe_pkg::HDR_BYTES + inner_hdr[0][15:0]};
        outer[1] = 32'h0;
        outer[2] = {ipe_pkg::OUTER_TTL, ipe_pkg::OUTER_PROTO, 16'h0};
        outer[3] = src_addr;
        outer[4] = hop;
        csum = 32'h0;
        for (int k = 0; k < 5; k++) csum += outer[k][31:16] + outer[k][15:0];
        while (csum[31:16] != 16'h0) csum = csum[15:0] + csum[31:16];
        outer[2][15:0] = ~csum[15:0];
        for (int k = 0; k < 5; k++) begin
            b = '{outer[k], 1'b0, ipe_pkg::WORD_BYTES, k == 0, (k == 0) ? hop : 32'h0,
                  1'b0};
            if (keep) expected_beats.push_back(b);
        end
        for (int k = 0; k < 5; k++) begin
            b = '{inner_hdr[k], (k == 4) ? it.last : 1'b0, ipe_pkg::WORD_BYTES, 1'b0,
                  32'h0, 1'b0};
            if (keep) expected_beats.push_back(b);
        end
        hdr_pos = it.last ? 3'd0 : ipe_pkg::POS_PASS;
    endtask

    // packet word, binding fields carry random noise
    function automatic t_pkt_item pkt_word(input logic [31:0] w, input logic l,
                                           input logic [2:0] v);
        return '{ipe_pkg::CMD_PKT, w, l, v, 3'($urandom_range(7)), 32'($urandom),
                 32'($urandom), 1'($urandom_range(1))};
    endfunction

    function automatic t_pkt_item bind_write(input logic [2:0] idx,
                                             input logic [31:0] home,
                                             input logic [31:0] care,
                                             input logic en);
        return '{ipe_pkg::CMD_BIND, 32'($urandom), 1'($urandom_range(1)),
                 3'($urandom_range(7)), idx, home, care, en};
    endfunction

    function automatic t_pkt_item rand_binding();
        logic [31:0] home;
        home = ($urandom_range(9) < 6) ? home_pool[$urandom_range(3)] : 32'($urandom);
        return bind_write(3'($urandom_range(7)), home, 32'($urandom),
                          $urandom_range(3) != 0);
    endfunction

    task automatic send_item(input t_pkt_item it, input bit typed, input t_beat want);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, it.en, it.care, it.home, it.idx, it.vb, it.word};
        s_axis_tlast  <= it.last;
        s_axis_tuser  <= it.cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        encap_predict(it, !typed);
        if (typed) expected_beats.push_back(want);
    endtask

    task automatic drain_outputs();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_beats.size() != 0);
    endtask

    task automatic write_source_addr(input logic [31:0] value);
        drain_outputs();
        repeat (8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        src_addr = value;
    endtask

    task automatic send_traffic(input int n_items, input bit pause_mid);
        t_pkt_item frame [$];
        int        sent;
        int        len;
        int        kind;
        logic [2:0] vb;
        bit        paused;
        sent = 0;
        paused = 0;
        while (sent < n_items) begin
            frame.delete();
            kind = $urandom_range(99);
            if (kind < 12) begin
                frame.push_back(rand_binding());
            end else if (kind < 22) begin
                len = $urandom_range(1, 5);
                for (int k = 0; k < len; k++) begin
                    vb = (len == 5) ? 3'($urandom_range(1, 3)) : 3'($urandom_range(7));
                    frame.push_back(pkt_word(32'($urandom), k == len - 1, vb));
                end
            end else begin
                len = 5 + (($urandom_range(3) == 0) ? $urandom_range(0, 6)
                                                     : $urandom_range(0, 2));
                for (int k = 0; k < len; k++) begin
                    logic [31:0] w;
                    w = 32'($urandom);
                    if (k == 4 && $urandom_range(9) < 7) w = home_pool[$urandom_range(3)];
                    vb = 3'($urandom_range(7));
                    if (k == len - 1 && len == 5) vb = 3'($urandom_range(4, 8) % 8);
                    if ($urandom_range(19) == 0) frame.push_back(rand_binding());
                    frame.push_back(pkt_word(w, k == len - 1, vb));
                end
            end
            foreach (frame[k]) send_item(frame[k], 1'b0, '0);
            sent += frame.size();
            if (pause_mid && !paused && sent >= n_items / 2) begin
                paused = 1;
                drain_outputs();
            end
        end
    endtask

    // output side: check every transaction, drive backpressure
    initial begin
        t_beat seen;
        t_beat want;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                seen = '{m_axis_tdata[31:0], m_axis_tlast, m_axis_tdata[34:32],
                         m_axis_tuser[0], m_axis_tdata[66:35], m_axis_tuser[1]};
                if (expected_beats.size() == 0) begin
                    note_mismatch("unexpected transaction, word", seen.word, 32'h0);
                end else begin
                    want = expected_beats.pop_front();
                    if (seen.word != want.word)
                        note_mismatch("out_word", seen.word, want.word);
                    if (seen.last != want.last)
                        note_mismatch("out_last", seen.last, want.last);
                    if (seen.bytes != want.bytes)
                        note_mismatch("out_bytes", seen.bytes, want.bytes);
                    if (seen.first != want.first)
                        note_mismatch("out_first", seen.first, want.first);
                    if (seen.hop != want.hop)
                        note_mismatch("next_hop", seen.hop, want.hop);
                    if (seen.runt != want.runt)
                        note_mismatch("runt_dropped", seen.runt, want.runt);
                end
            end
            if (hold_cycles_left > 0) begin
                hold_cycles_left--;
                m_axis_tready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 0;
                hold_cycles_left = 400;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        mismatches = 0;
        hold_cycles_left = 0;
        hold_request = 0;
        send_idle_pct = 22;
        recv_idle_pct = 57;
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= 32'h0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        s_axis_tuser  <= ipe_pkg::CMD_PKT;

        src_addr = 32'h0;
        hdr_pos = 3'd0;
        for (int i = 0; i < NUM_BINDINGS; i++) begin
            bind_home[i]  = 32'h0;
            bind_care[i]  = 32'h0;
            bind_valid[i] = 1'b0;
        end
        home_pool[0] = HOME_A;
        home_pool[1] = HOME_B;
        home_pool[2] = 32'($urandom);
        home_pool[3] = 32'($urandom);

        // runt right after reset
        directed_rows.push_back('{pkt_word(32'h4500_0014, 1'b1, 3'd1), 1'b1, RUNT_BEAT});
        // two bindings for one home, lowest slot wins; a disabled one
        directed_rows.push_back('{bind_write(3'd0, HOME_A, CARE_0, 1'b1), 1'b0, '0});
        directed_rows.push_back('{bind_write(3'd7, HOME_A, CARE_7, 1'b1), 1'b0, '0});
        directed_rows.push_back('{bind_write(3'd3, HOME_B, CARE_3, 1'b0), 1'b0, '0});
        // max tos and length wrap, bound destination
        directed_rows.push_back('{pkt_word(32'h45FF_FFFF, 1'b0, 3'd4), 1'b0, '0});
        directed_rows.push_back('{pkt_word(32'hFFFF_FFFF, 1'b0, 3'd4), 1'b0, '0});
        directed_rows.push_back('{pkt_word(32'h0000_0000, 1'b0, 3'd4), 1'b0, '0});
        directed_rows.push_back('{pkt_word(32'hAAAA_5555, 1'b0, 3'd4), 1'b0, '0});
        directed_rows.push_back('{pkt_word(HOME_A, 1'b0, 3'd4), 1'b0, '0});
        directed_rows.push_back('{pkt_word(32'h8000_0001, 1'b1, 3'd0), 1'b1,
                                  '{32'h8000_0001, 1'b1, 3'd4, 1'b0, 32'h0, 1'b0}});
        // exactly twenty bytes, destination only in a disabled binding
        for (int k = 0; k < 4; k++)
            directed_rows.push_back('{pkt_word(32'h0, 1'b0, 3'd4), 1'b0, '0});
        directed_rows.push_back('{pkt_word(HOME_B, 1'b1, 3'd4), 1'b0, '0});
        // twenty-byte header ending short on the fifth word
        directed_rows.push_back('{pkt_word(32'h4500_0028, 1'b0, 3'd4), 1'b0, '0});
        for (int k = 0; k < 3; k++)
            directed_rows.push_back('{pkt_word(32'h1, 1'b0, 3'd4), 1'b0, '0});
        directed_rows.push_back('{pkt_word(32'hFFFF_FFFF, 1'b1, 3'd3), 1'b1, RUNT_BEAT});
        // all ones, byte counts ignored on non-last words
        directed_rows.push_back('{pkt_word(32'hFFFF_FFFF, 1'b0, 3'd7), 1'b0, '0});
        directed_rows.push_back('{pkt_word(32'hFFFF_FFFF, 1'b0, 3'd6), 1'b0, '0});
        directed_rows.push_back('{pkt_word(32'hFFFF_FFFF, 1'b0, 3'd5), 1'b0, '0});
        directed_rows.push_back('{pkt_word(32'hFFFF_FFFF, 1'b0, 3'd2), 1'b0, '0});
        directed_rows.push_back('{pkt_word(32'hFFFF_FFFF, 1'b0, 3'd0), 1'b0, '0});
        directed_rows.push_back('{pkt_word(32'h1234_5678, 1'b1, 3'd5), 1'b1,
                                  '{32'h1234_5678, 1'b1, 3'd4, 1'b0, 32'h0, 1'b0}});

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r])
            send_item(directed_rows[r].it, directed_rows[r].typed, directed_rows[r].want);

        write_source_addr(32'hFFFF_FFFF);
        send_traffic(170, 1'b0);

        send_idle_pct = 57;
        recv_idle_pct = 22;
        write_source_addr(32'($urandom));
        send_traffic(170, 1'b1);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_source_addr(32'h0);
        hold_request = 1;
        send_traffic(170, 1'b0);

        drain_outputs();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
